// File: sv/bqnotch_pkg.sv
// ----------------------------------------------------------------------------
// bqnotch_pkg
// Shared types, constants and the coefficient rom of the biquad notch filter.
// ----------------------------------------------------------------------------
package bqnotch_pkg;

   // fixed sizes of the filter
   localparam int SECTIONS             = 4;
   localparam int SEC_W                = $clog2(SECTIONS);
   localparam int NSETS                = 6;
   localparam int MODE_W               = 3;
   localparam int HIST_W               = 32;
   localparam int COEF_W               = 32;
   localparam int PROD_W               = HIST_W + COEF_W;
   localparam int ACC_W                = PROD_W + 2;
   localparam int COEF_FRAC            = 30;
   localparam int SAMPLE_WIDTH_DEFAULT = 24;

   // configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MODE = 1'b0;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // order in which the five products of a section are formed;
   // the current input comes last so the previous section can finish first
   typedef enum logic [2:0] {
      TAP_X1,
      TAP_X2,
      TAP_Y1,
      TAP_Y2,
      TAP_X
   } tap_type;

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             issue;
      logic [SEC_W-1:0] sec;
      tap_type          tap;
      logic             out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
   } status_type;

   // one section's coefficients: b0, b1, b2, a0, a1 from the lowest slot up
   typedef logic [4:0][COEF_W-1:0] coef_row_type;

   // decimal design value (times 10^12) to q2.30, rounded to nearest
   function automatic logic [COEF_W-1:0] q30(input longint unsigned c);
      longint unsigned t;
      t = (c * 64'd262144 + 64'd122070312) / 64'd244140625;
      return t[COEF_W-1:0];
   endfunction

   // feed-forward pair is symmetric; b1 and a1 carry a negative sign
   function automatic coef_row_type make_row(input longint unsigned b0,
                                             input longint unsigned b1,
                                             input longint unsigned a0,
                                             input longint unsigned a1);
      coef_row_type row;
      row[0] = q30(b0);
      row[1] = -q30(b1);
      row[2] = q30(b0);
      row[3] = q30(a0);
      row[4] = -q30(a1);
      return row;
   endfunction

   // sets 0-2: 50 hz at 40/60/80 db, sets 3-5: 60 hz at 40/60/80 db
   localparam coef_row_type COEF_ROM [NSETS][SECTIONS] = '{
      '{make_row(64'd997682591232, 64'd1991694270059, 64'd1993991099002, 64'd997449015889),
        make_row(64'd997682591232, 64'd1991225875619, 64'd1992719432869, 64'd997122121373),
        make_row(64'd997682591232, 64'd1991562861801, 64'd1989918295292, 64'd993622497931),
        make_row(64'd997682591232, 64'd1991368918450, 64'd1989201706440, 64'd993295984254)},
      '{make_row(64'd997516583626, 64'd1991267524831, 64'd1993792556381, 64'd997261542221),
        make_row(64'd997516583626, 64'd1990999323659, 64'd1992532991646, 64'd996920780978),
        make_row(64'd997516583626, 64'd1991190872529, 64'd1989453530594, 64'd993161909468),
        make_row(64'd997516583626, 64'd1991079793498, 64'd1988733858877, 64'd992821608511)},
      '{make_row(64'd997462788341, 64'd1991103458477, 64'd1993728075618, 64'd997200655249),
        make_row(64'd997462788341, 64'd1990951762853, 64'd1992472700971, 64'd996855673897),
        make_row(64'd997462788341, 64'd1991059637418, 64'd1989302815679, 64'd993012548252),
        make_row(64'd997462788341, 64'd1990996805483, 64'd1988582415484, 64'd992668052597)},
      '{make_row(64'd997682591234, 64'd1990009760159, 64'd1992325153524, 64'd997421548427),
        make_row(64'd997682591234, 64'd1989447061155, 64'd1990918758069, 64'd997149580589),
        make_row(64'd997682591234, 64'd1989850731814, 64'd1988199921793, 64'd993594951604),
        make_row(64'd997682591234, 64'd1989617713958, 64'd1987460059960, 64'd993323522293)},
      '{make_row(64'd997516583631, 64'd1989563160946, 64'd1992123011711, 64'd997232903629),
        make_row(64'd997516583631, 64'd1989240931265, 64'd1990736250797, 64'd996949410606),
        make_row(64'd997516583631, 64'd1989470683554, 64'd1987733301547, 64'd993133190117),
        make_row(64'd997516583631, 64'd1989337222874, 64'd1986994878892, 64'd992850318851)},
      '{make_row(64'd997462788347, 64'd1989387454539, 64'd1992057387679, 64'd997171660034),
        make_row(64'd997462788347, 64'd1989205194537, 64'd1990677211885, 64'd996884659925),
        make_row(64'd997462788347, 64'd1989334681058, 64'd1987582008256, 64'd992983471531),
        make_row(64'd997462788347, 64'd1989259188525, 64'd1986844276615, 64'd992697120082)}
   };

   // coefficient for one product; modes without a set read zero
   function automatic logic [COEF_W-1:0] coef_for(input logic [MODE_W-1:0] mode,
                                                  input logic [SEC_W-1:0]  sec,
                                                  input tap_type           tap);
      logic [2:0] slot;
      unique case (tap)
         TAP_X1:  slot = 3'd1;
         TAP_X2:  slot = 3'd2;
         TAP_Y1:  slot = 3'd3;
         TAP_Y2:  slot = 3'd4;
         TAP_X:   slot = 3'd0;
         default: slot = 3'd0;
      endcase
      if (mode < MODE_W'(NSETS)) begin
         return COEF_ROM[mode][sec][slot];
      end
      return '0;
   endfunction

endpackage

// File: sv/bqnotch_ctrl.sv
// ----------------------------------------------------------------------------
// bqnotch_ctrl
// Sequencer: takes a sample, steps the shared multiplier through every section
// and tap if the mode has a set, then loads the result register when free.
// ----------------------------------------------------------------------------
module bqnotch_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bqnotch_pkg::MODE_W-1:0]      mode,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output bqnotch_pkg::cmd_type                cmd,
   input  bqnotch_pkg::status_type             status
);

   bqnotch_pkg::state_type              state_ff, state_in;
   logic [bqnotch_pkg::SEC_W-1:0]        sec_ff, sec_in;
   bqnotch_pkg::tap_type                tap_ff, tap_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_free;
   logic                                bypass;

   // modes without a coefficient set only repeat the last output
   assign bypass   = (mode >= bqnotch_pkg::MODE_W'(bqnotch_pkg::NSETS));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqnotch_pkg::ST_IDLE;
         sec_ff       <= '0;
         tap_ff       <= bqnotch_pkg::TAP_X1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      tap_in       = tap_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.sec      = sec_ff;
      cmd.tap      = tap_ff;

      unique case (state_ff)
         bqnotch_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               sec_in   = '0;
               tap_in   = bqnotch_pkg::TAP_X1;
               state_in = bypass ? bqnotch_pkg::ST_FINISH : bqnotch_pkg::ST_RUN;
            end
         end
         bqnotch_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            unique case (tap_ff)
               bqnotch_pkg::TAP_X1: tap_in = bqnotch_pkg::TAP_X2;
               bqnotch_pkg::TAP_X2: tap_in = bqnotch_pkg::TAP_Y1;
               bqnotch_pkg::TAP_Y1: tap_in = bqnotch_pkg::TAP_Y2;
               bqnotch_pkg::TAP_Y2: tap_in = bqnotch_pkg::TAP_X;
               default: begin
                  tap_in = bqnotch_pkg::TAP_X1;
                  sec_in = sec_ff + 1'b1;
                  if (sec_ff == bqnotch_pkg::SEC_W'(bqnotch_pkg::SECTIONS - 1)) begin
                     state_in = bqnotch_pkg::ST_FINISH;
                  end
               end
            endcase
         end
         bqnotch_pkg::ST_FINISH: begin
            // wait for the last section to write back and the output to drain
            if (!status.busy && out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bqnotch_pkg::ST_IDLE;
            end
         end
         default: state_in = bqnotch_pkg::ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: sv/bqnotch_dp.sv
// ----------------------------------------------------------------------------
// bqnotch_dp
// Datapath: section histories, operand select with coefficient rom, one
// registered 32x32 multiplier, accumulator with rounding and saturation,
// and the result register.
// ----------------------------------------------------------------------------
module bqnotch_dp #(
   parameter int SAMPLE_WIDTH = bqnotch_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [bqnotch_pkg::MODE_W-1:0]      mode,
   input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
   output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
   input  bqnotch_pkg::cmd_type                cmd,
   output bqnotch_pkg::status_type             status
);

   localparam int HIST_W = bqnotch_pkg::HIST_W;
   localparam int ACC_W  = bqnotch_pkg::ACC_W;
   localparam int SEC_W  = bqnotch_pkg::SEC_W;
   localparam int SECS   = bqnotch_pkg::SECTIONS;
   // scaled sample, never narrower than the history plus a sign bit
   localparam int EXT_W  = (SAMPLE_WIDTH + 9 > HIST_W + 1) ? SAMPLE_WIDTH + 9 : HIST_W + 1;
   localparam int RND_W  = HIST_W + 2;

   localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(64'sd1 <<< (bqnotch_pkg::COEF_FRAC - 1));
   localparam logic signed [ACC_W-1:0] ACC_HI    = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] ACC_LO    = -ACC_HI - ACC_W'(1);
   localparam logic signed [EXT_W-1:0] IN_HI     = EXT_W'(64'sd2147483647);
   localparam logic signed [EXT_W-1:0] IN_LO     = -IN_HI - EXT_W'(1);
   localparam logic signed [RND_W-1:0] OUT_HI    = RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] OUT_LO    = -OUT_HI - RND_W'(1);

   // per-section history
   logic signed [HIST_W-1:0] hist_x1_ff [SECS];
   logic signed [HIST_W-1:0] hist_x2_ff [SECS];
   logic signed [HIST_W-1:0] hist_y1_ff [SECS];
   logic signed [HIST_W-1:0] hist_y2_ff [SECS];

   // current section input and accumulator
   logic signed [HIST_W-1:0] x_cur_ff, x_cur_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;

   // operand stage
   logic                             v1_ff, last1_ff;
   logic [SEC_W-1:0]                 sec1_ff;
   logic signed [bqnotch_pkg::COEF_W-1:0] opa_ff;
   logic signed [HIST_W-1:0]         opb_ff, opb_in;

   // product stage
   logic                                    v2_ff, last2_ff;
   logic [SEC_W-1:0]                        sec2_ff;
   logic signed [bqnotch_pkg::PROD_W-1:0]   prod_ff;

   logic signed [SAMPLE_WIDTH-1:0]  out_ff;

   logic signed [EXT_W-1:0]  scaled;
   logic signed [HIST_W-1:0] x_entry;
   logic signed [ACC_W-1:0]  acc_sum, acc_shift;
   logic signed [HIST_W-1:0] sec_result;
   logic signed [RND_W-1:0]  y_round;
   logic signed [SAMPLE_WIDTH-1:0] out_in;
   logic                     finish;

   // input sample to q23.8, saturated to the history width
   always_comb begin
      scaled = EXT_W'(sample_in) <<< 8;
      if (scaled > IN_HI) begin
         x_entry = IN_HI[HIST_W-1:0];
      end else if (scaled < IN_LO) begin
         x_entry = IN_LO[HIST_W-1:0];
      end else begin
         x_entry = scaled[HIST_W-1:0];
      end
   end

   // data operand for the tap being issued
   always_comb begin
      unique case (cmd.tap)
         bqnotch_pkg::TAP_X1: opb_in = hist_x1_ff[cmd.sec];
         bqnotch_pkg::TAP_X2: opb_in = hist_x2_ff[cmd.sec];
         bqnotch_pkg::TAP_Y1: opb_in = hist_y1_ff[cmd.sec];
         bqnotch_pkg::TAP_Y2: opb_in = hist_y2_ff[cmd.sec];
         default:             opb_in = x_cur_ff;
      endcase
   end

   // operand and product registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
      last1_ff <= (cmd.tap == bqnotch_pkg::TAP_X);
      sec1_ff  <= cmd.sec;
      opa_ff   <= bqnotch_pkg::coef_for(mode, cmd.sec, cmd.tap);
      opb_ff   <= opb_in;
      last2_ff <= last1_ff;
      sec2_ff  <= sec1_ff;
      prod_ff  <= opa_ff * opb_ff;
   end

   // accumulate; the sum already carries the rounding constant
   always_comb begin
      acc_sum   = acc_ff + ACC_W'(prod_ff);
      acc_shift = acc_sum >>> bqnotch_pkg::COEF_FRAC;
      if (acc_shift > ACC_HI) begin
         sec_result = ACC_HI[HIST_W-1:0];
      end else if (acc_shift < ACC_LO) begin
         sec_result = ACC_LO[HIST_W-1:0];
      end else begin
         sec_result = acc_shift[HIST_W-1:0];
      end
      finish = v2_ff && last2_ff;
   end

   always_comb begin
      acc_in   = acc_ff;
      x_cur_in = x_cur_ff;
      if (cmd.load) begin
         acc_in   = ACC_ROUND;
         x_cur_in = x_entry;
      end else if (finish) begin
         acc_in   = ACC_ROUND;
         x_cur_in = sec_result;
      end else if (v2_ff) begin
         acc_in = acc_sum;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      x_cur_ff <= x_cur_in;
   end

   // history shift of the section that just finished
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECS; i++) begin
            hist_x1_ff[i] <= '0;
            hist_x2_ff[i] <= '0;
            hist_y1_ff[i] <= '0;
            hist_y2_ff[i] <= '0;
         end
      end else if (finish) begin
         hist_x1_ff[sec2_ff] <= x_cur_ff;
         hist_x2_ff[sec2_ff] <= hist_x1_ff[sec2_ff];
         hist_y1_ff[sec2_ff] <= sec_result;
         hist_y2_ff[sec2_ff] <= hist_y1_ff[sec2_ff];
      end
   end

   // last section output to integer, round half up, saturate
   always_comb begin
      y_round = (RND_W'(hist_y1_ff[SECS-1]) + RND_W'(128)) >>> 8;
      if (y_round > OUT_HI) begin
         out_in = OUT_HI[SAMPLE_WIDTH-1:0];
      end else if (y_round < OUT_LO) begin
         out_in = OUT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         out_in = y_round[SAMPLE_WIDTH-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign sample_out  = out_ff;
   assign status.busy = v1_ff || v2_ff;

endmodule

// File: sv/biquad_cascade_notch_filter.sv
// ----------------------------------------------------------------------------
// biquad_cascade_notch_filter
// Mains-hum notch: four cascaded biquad sections on one shared multiplier.
// ----------------------------------------------------------------------------
// Each sample goes through four second-order sections, five products per
// section, all on one registered 32x32 multiplier. After the sample is
// accepted the products are issued in turn, the pipeline drains and the
// result is loaded before the next sample. A new sample is taken while the
// previous result still waits on the output. The mode register (address 0)
// selects the coefficient set: 0-2 notch 50 hz at 40/60/80 db, 3-5 notch
// 60 hz; modes 6 and 7 leave the history alone and repeat the last output.
// Write mode only while the filter is idle. Samples are signed, history is
// q23.8, coefficients are q2.30; every section rounds and saturates.
// ----------------------------------------------------------------------------
module biquad_cascade_notch_filter #(
   parameter int SAMPLE_WIDTH = bqnotch_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,   // sample_in
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,   // sample_out
   // configuration port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [bqnotch_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bqnotch_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bqnotch_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   logic [bqnotch_pkg::MODE_W-1:0] mode_ff;
   logic                           csr_write;
   bqnotch_pkg::cmd_type           cmd;
   bqnotch_pkg::status_type        status;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   // mode register write
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == bqnotch_pkg::CSR_IDX_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else if (csr_write) begin
         mode_ff <= csr_pwdata[bqnotch_pkg::MODE_W-1:0];
      end
   end

   // register read back
   always_comb begin
      if (csr_paddr[2] == bqnotch_pkg::CSR_IDX_MODE) begin
         csr_prdata = bqnotch_pkg::CSR_DATA_W'(mode_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   bqnotch_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bqnotch_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .sample_in  (signed'(req_tdata[SAMPLE_WIDTH-1:0])),
      .sample_out (sample_out),
      .cmd        (cmd),
      .status     (status)
   );

   assign rsp_tdata = TDATA_W'($unsigned(sample_out));

endmodule

// File: verif/biquad_cascade_notch_filter_checker.sv
// ----------------------------------------------------------------------------
// biquad_cascade_notch_filter_checker
// Watches the sample, result and register ports of the notch filter and
// compares every result with a cycle-free model of the four biquad sections.
// ----------------------------------------------------------------------------
// The model keeps its own mode and x/y delay lines, runs each accepted sample
// through the cascade in q23.8 with q2.30 coefficients (exact sum, round half
// up, saturate) and queues the rounded output. Results are popped in order.
// Register reads are checked against the tracked mode.
// ----------------------------------------------------------------------------
module biquad_cascade_notch_filter_checker #(
   parameter int SAMPLE_WIDTH = bqnotch_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int DATA_W       = ((SAMPLE_WIDTH+7)/8)*8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [DATA_W-1:0]                   req_tdata,   // sample_in
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [DATA_W-1:0]                   rsp_tdata,   // sample_out
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bqnotch_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bqnotch_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [bqnotch_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count
);
   import bqnotch_pkg::*;

   // wide enough for five exact 32x32 products
   typedef logic signed [ACC_W:0]        wide_type;
   typedef logic signed [HIST_W-1:0]     hist_type;
   typedef logic [SAMPLE_WIDTH-1:0]      sample_type;

   localparam int HIST_FRAC   = 8;
   localparam int MAX_REPORTS = 30;

   // position of each design value within a row
   localparam int DESIGN_B0 = 0;
   localparam int DESIGN_B1 = 1;
   localparam int DESIGN_A0 = 2;
   localparam int DESIGN_A1 = 3;

   // design values times 10^12; b2 equals b0, b1 and a1 are negated
   localparam longint unsigned NOTCH_DESIGN [NSETS][SECTIONS][4] = '{
      '{'{64'd997682591232, 64'd1991694270059, 64'd1993991099002, 64'd997449015889},
        '{64'd997682591232, 64'd1991225875619, 64'd1992719432869, 64'd997122121373},
        '{64'd997682591232, 64'd1991562861801, 64'd1989918295292, 64'd993622497931},
        '{64'd997682591232, 64'd1991368918450, 64'd1989201706440, 64'd993295984254}},
      '{'{64'd997516583626, 64'd1991267524831, 64'd1993792556381, 64'd997261542221},
        '{64'd997516583626, 64'd1990999323659, 64'd1992532991646, 64'd996920780978},
        '{64'd997516583626, 64'd1991190872529, 64'd1989453530594, 64'd993161909468},
        '{64'd997516583626, 64'd1991079793498, 64'd1988733858877, 64'd992821608511}},
      '{'{64'd997462788341, 64'd1991103458477, 64'd1993728075618, 64'd997200655249},
        '{64'd997462788341, 64'd1990951762853, 64'd1992472700971, 64'd996855673897},
        '{64'd997462788341, 64'd1991059637418, 64'd1989302815679, 64'd993012548252},
        '{64'd997462788341, 64'd1990996805483, 64'd1988582415484, 64'd992668052597}},
      '{'{64'd997682591234, 64'd1990009760159, 64'd1992325153524, 64'd997421548427},
        '{64'd997682591234, 64'd1989447061155, 64'd1990918758069, 64'd997149580589},
        '{64'd997682591234, 64'd1989850731814, 64'd1988199921793, 64'd993594951604},
        '{64'd997682591234, 64'd1989617713958, 64'd1987460059960, 64'd993323522293}},
      '{'{64'd997516583631, 64'd1989563160946, 64'd1992123011711, 64'd997232903629},
        '{64'd997516583631, 64'd1989240931265, 64'd1990736250797, 64'd996949410606},
        '{64'd997516583631, 64'd1989470683554, 64'd1987733301547, 64'd993133190117},
        '{64'd997516583631, 64'd1989337222874, 64'd1986994878892, 64'd992850318851}},
      '{'{64'd997462788347, 64'd1989387454539, 64'd1992057387679, 64'd997171660034},
        '{64'd997462788347, 64'd1989205194537, 64'd1990677211885, 64'd996884659925},
        '{64'd997462788347, 64'd1989334681058, 64'd1987582008256, 64'd992983471531},
        '{64'd997462788347, 64'd1989259188525, 64'd1986844276615, 64'd992697120082}}
   };

   // tracked register and delay lines
   logic [MODE_W-1:0] mode_shadow;
   hist_type          x_delay [2*SECTIONS];
   hist_type          y_delay [2*SECTIONS];
   sample_type        expected_out [$];
   int                mismatches;

   assign fail_count = mismatches;

   initial mismatches = 0;

   // decimal design value to q2.30, nearest
   function automatic longint q30_of(input longint unsigned v);
      return longint'((v * 64'd262144 + 64'd122070312) / 64'd244140625);
   endfunction

   function automatic longint tap_coef(input int set, input int sec, input tap_type tap);
      case (tap)
         TAP_X, TAP_X2: return q30_of(NOTCH_DESIGN[set][sec][DESIGN_B0]);
         TAP_X1:        return -q30_of(NOTCH_DESIGN[set][sec][DESIGN_B1]);
         TAP_Y1:        return q30_of(NOTCH_DESIGN[set][sec][DESIGN_A0]);
         default:       return -q30_of(NOTCH_DESIGN[set][sec][DESIGN_A1]);
      endcase
   endfunction

   // clamp to a signed range of the given width
   function automatic wide_type clamp_signed(input wide_type v, input int w);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // one biquad: five exact products, round to q23.8, saturate, shift history
   function automatic hist_type biquad_section(input int sec, input hist_type x);
      int       k;
      int       set;
      wide_type acc;
      hist_type y;
      k   = 2 * sec;
      set = int'(mode_shadow);
      acc = wide_type'(tap_coef(set, sec, TAP_X))  * wide_type'(x)
          + wide_type'(tap_coef(set, sec, TAP_X1)) * wide_type'(x_delay[k])
          + wide_type'(tap_coef(set, sec, TAP_X2)) * wide_type'(x_delay[k+1])
          + wide_type'(tap_coef(set, sec, TAP_Y1)) * wide_type'(y_delay[k])
          + wide_type'(tap_coef(set, sec, TAP_Y2)) * wide_type'(y_delay[k+1]);
      y = hist_type'(clamp_signed((acc + (wide_type'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC,
                                  HIST_W));
      x_delay[k+1] = x_delay[k];
      x_delay[k]   = x;
      y_delay[k+1] = y_delay[k];
      y_delay[k]   = y;
      return y;
   endfunction

   // whole cascade for one sample; modes without a set repeat the last output
   function automatic sample_type notch_cascade(input sample_type raw);
      logic signed [SAMPLE_WIDTH-1:0] s;
      hist_type                        x;
      wide_type                        o;
      int                              sec;
      s = $signed(raw);
      if (mode_shadow < MODE_W'(NSETS)) begin
         x = hist_type'(clamp_signed(wide_type'(s) <<< HIST_FRAC, HIST_W));
         for (sec = 0; sec < SECTIONS; sec++) begin
            x = biquad_section(sec, x);
         end
      end else begin
         x = y_delay[2*(SECTIONS-1)];
      end
      o = clamp_signed((wide_type'(x) + (wide_type'(1) <<< (HIST_FRAC - 1))) >>> HIST_FRAC,
                       SAMPLE_WIDTH);
      return o[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch %0d at %0t: %s: got 0x%0h, expected 0x%0h",
                  mismatches, $time, what, got, want);
      end
   endtask

   // follow the bus and compare
   always @(posedge clock) begin
      if (reset) begin
         mode_shadow = '0;
         foreach (x_delay[i]) x_delay[i] = '0;
         foreach (y_delay[i]) y_delay[i] = '0;
         expected_out.delete();
      end else begin
         // register write, only the mode index is mapped
         if (csr_psel && csr_penable && csr_pready && csr_pwrite) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W-2)'(CSR_IDX_MODE)) begin
               mode_shadow = csr_pwdata[MODE_W-1:0];
            end
         end
         // register read back
         if (csr_psel && csr_penable && csr_pready && !csr_pwrite &&
             csr_paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W-2)'(CSR_IDX_MODE)) begin
            if (csr_prdata != CSR_DATA_W'(mode_shadow)) begin
               report_mismatch("mode read back", longint'(csr_prdata),
                               longint'(mode_shadow));
            end
         end
         // result transaction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out.size() == 0) begin
               report_mismatch("result with no sample outstanding",
                               longint'(rsp_tdata), 0);
            end else if (rsp_tdata[SAMPLE_WIDTH-1:0] != expected_out[0]) begin
               report_mismatch("sample_out", longint'(rsp_tdata[SAMPLE_WIDTH-1:0]),
                               longint'(expected_out[0]));
               void'(expected_out.pop_front());
            end else begin
               void'(expected_out.pop_front());
            end
         end
         // sample transaction
         if (req_tvalid && req_tready) begin
            expected_out.push_back(notch_cascade(req_tdata[SAMPLE_WIDTH-1:0]));
         end
      end
   end

endmodule

// File: verif/biquad_cascade_notch_filter_tb.sv
// ----------------------------------------------------------------------------
// biquad_cascade_notch_filter_tb
// Stimulus and verdict for the four-section biquad notch filter.
// ----------------------------------------------------------------------------
// A short directed pass hits full-scale steps and alternating extremes, the
// two modes that repeat the last output, a write to an unmapped address and
// register read back. Then every mode runs random bursts of noise, full-scale
// square waves, quiet signals and held levels, with random sender gaps, a
// changing receiver stall pattern and one long output hold-off. The checker
// beside the filter predicts and compares every result.
// ----------------------------------------------------------------------------
module biquad_cascade_notch_filter_tb;
   import bqnotch_pkg::*;

   localparam int CLOCK_PERIOD     = 4;
   localparam int RESET_CYCLES     = 7;
   localparam int SAMPLE_W         = SAMPLE_WIDTH_DEFAULT;
   localparam int DATA_W           = ((SAMPLE_W+7)/8)*8;
   localparam int LIMIT_TIME       = 2_000_000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int HOLDOFF_AT       = 610;
   localparam int HOLDOFF_CYCLES   = 400;
   localparam int PHASE_ITEMS      = 220;
   localparam int HOLD_PHASE_ITEMS = 40;
   localparam int PHASES           = 10;

   // register map
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR   = CSR_ADDR_W'(4 * CSR_IDX_MODE);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);

   // mode settings
   localparam logic [MODE_W-1:0] MODE_50HZ_40DB = 3'd0;
   localparam logic [MODE_W-1:0] MODE_50HZ_60DB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_50HZ_80DB = 3'd2;
   localparam logic [MODE_W-1:0] MODE_60HZ_40DB = 3'd3;
   localparam logic [MODE_W-1:0] MODE_60HZ_60DB = 3'd4;
   localparam logic [MODE_W-1:0] MODE_60HZ_80DB = 3'd5;
   localparam logic [MODE_W-1:0] MODE_FREEZE_6  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_FREEZE_7  = 3'd7;

   localparam logic [MODE_W-1:0] PHASE_PLAN [PHASES] = '{
      MODE_50HZ_60DB, MODE_50HZ_40DB, MODE_FREEZE_6, MODE_50HZ_80DB, MODE_60HZ_40DB,
      MODE_FREEZE_7, MODE_60HZ_60DB, MODE_60HZ_80DB, MODE_50HZ_40DB, MODE_60HZ_80DB
   };

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // full-scale steps and alternation to push the sections into saturation
   localparam logic [SAMPLE_W-1:0] DIRECTED_50HZ [14] = '{
      '0, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
      SAMPLE_W'(1), '1, SAMPLE_W'(24'h555555), SAMPLE_W'(24'haaaaaa), '0,
      SAMPLE_MIN, SAMPLE_MIN
   };
   localparam logic [SAMPLE_W-1:0] DIRECTED_60HZ [4] = '{
      SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, '0
   };

   typedef enum int {
      SRC_NOISE,
      SRC_SQUARE,
      SRC_QUIET,
      SRC_LEVEL
   } source_kind_type;

   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_HALF
   } stall_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;    // sample_in
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;    // sample_out
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  fail_count;
   int  items_sent;
   int  results_seen;
   int  input_stalls;
   bit  holdoff_done;

   biquad_cascade_notch_filter #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   biquad_cascade_notch_filter_checker #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   // transaction and back-pressure counts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
      end
      if (!reset && req_tvalid && !req_tready) begin
         input_stalls <= input_stalls + 1;
      end
   end

   // one sample transaction; tvalid stays high for a following sample
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(s);
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // wait until every accepted sample has come back
   task automatic drain_filter;
      req_tvalid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   // setup and access cycle; psel stays high, caller either chains or idles
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // write a register, read the mode back, release the bus
   task automatic program_reg(input logic [CSR_ADDR_W-1:0] addr,
                              input logic [CSR_DATA_W-1:0] data);
      csr_access(1'b1, addr, data);
      csr_access(1'b0, MODE_ADDR, '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input source_kind_type kind,
                                                       input int idx, input int period,
                                                       input logic [SAMPLE_W-1:0] level);
      logic [SAMPLE_W-1:0] v;
      case (kind)
         SRC_SQUARE: v = ((idx / period) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
         SRC_QUIET:  v = SAMPLE_W'($urandom_range(0, 600) - 300);
         SRC_LEVEL:  v = level ^ SAMPLE_W'($urandom_range(0, 15));
         default:    v = SAMPLE_W'($urandom);
      endcase
      return v;
   endfunction

   // random bursts of one signal kind with random gaps between them
   task automatic run_phase(input int count);
      int                  sent;
      int                  len;
      int                  idx;
      int                  period;
      source_kind_type     kind;
      logic [SAMPLE_W-1:0] level;
      sent = 0;
      while (sent < count) begin
         kind   = source_kind_type'($urandom_range(0, 3));
         len    = $urandom_range(1, 48);
         period = $urandom_range(1, 40);
         level  = SAMPLE_W'($urandom);
         for (idx = 0; idx < len && sent < count; idx++) begin
            push_sample(pick_sample(kind, idx, period, level));
            sent++;
         end
         pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
      end
   endtask

   // receiver: changing stall styles, one long hold-off while samples keep coming
   initial begin : receiver
      stall_style_type style;
      int              span;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         style = stall_style_type'($urandom_range(0, 3));
         span  = $urandom_range(20, 300);
         repeat (span) begin
            if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
               holdoff_done = 1'b1;
               rsp_tready <= 1'b0;
               repeat (HOLDOFF_CYCLES) @(posedge clock);
            end
            case (style)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 2) != 0);
               READY_RARELY: rsp_tready <= ($urandom_range(0, 7) == 0);
               default:      rsp_tready <= ($urandom_range(0, 1) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_TIME);
      $display("biquad_cascade_notch_filter regression: fail");
      $finish;
   end

   // stimulus and verdict
   initial begin : stimulus
      int p;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      items_sent   = 0;
      results_seen = 0;
      input_stalls = 0;
      holdoff_done = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value, then repeat mode straight after reset gives zero
      csr_access(1'b0, MODE_ADDR, '0);
      program_reg(MODE_ADDR, CSR_DATA_W'(MODE_FREEZE_7));
      push_sample(SAMPLE_W'(24'h123456));
      drain_filter();

      // unmapped write leaves mode alone
      program_reg(UNUSED_ADDR, CSR_DATA_W'(MODE_60HZ_40DB));
      program_reg(MODE_ADDR, CSR_DATA_W'(MODE_50HZ_40DB));
      foreach (DIRECTED_50HZ[i]) push_sample(DIRECTED_50HZ[i]);
      drain_filter();

      // repeat mode holds the history and echoes the last output
      program_reg(MODE_ADDR, CSR_DATA_W'(MODE_FREEZE_6));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      drain_filter();

      program_reg(MODE_ADDR, CSR_DATA_W'(MODE_60HZ_80DB));
      foreach (DIRECTED_60HZ[i]) push_sample(DIRECTED_60HZ[i]);
      drain_filter();

      // random phases through every mode
      for (p = 0; p < PHASES; p++) begin
         program_reg(MODE_ADDR, CSR_DATA_W'(PHASE_PLAN[p]));
         run_phase((PHASE_PLAN[p] < MODE_W'(NSETS)) ? PHASE_ITEMS : HOLD_PHASE_ITEMS);
         drain_filter();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d samples through all eight mode settings, %0d results checked",
               items_sent, results_seen);
      $display("input stalled by processing or output back-pressure for %0d cycles, %0d mismatches",
               input_stalls, fail_count);
      if (fail_count == 0) begin
         $display("biquad_cascade_notch_filter regression: pass");
      end else begin
         $display("biquad_cascade_notch_filter regression: fail");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/bqnotch_pkg.sv
sv/bqnotch_ctrl.sv
sv/bqnotch_dp.sv
sv/biquad_cascade_notch_filter.sv
verif/biquad_cascade_notch_filter_checker.sv
verif/biquad_cascade_notch_filter_tb.sv
